### rtl/core/fpalu_pkg.sv
// fpalu_pkg: shared constants, operation codes and status structs for the
// Q24.8 fixed-point ALU. No dependencies; used by every other file in rtl/core.
package fpalu_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;
	localparam int FUNC_W        = 4;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_ADD      = 4'd0;
	localparam logic [FUNC_W-1:0] FN_SUB      = 4'd1;
	localparam logic [FUNC_W-1:0] FN_MUL      = 4'd2;
	localparam logic [FUNC_W-1:0] FN_DIV      = 4'd3;
	localparam logic [FUNC_W-1:0] FN_MIN      = 4'd4;
	localparam logic [FUNC_W-1:0] FN_MAX      = 4'd5;
	localparam logic [FUNC_W-1:0] FN_INC      = 4'd6;
	localparam logic [FUNC_W-1:0] FN_DEC      = 4'd7;
	localparam logic [FUNC_W-1:0] FN_TO_INT   = 4'd8;
	localparam logic [FUNC_W-1:0] FN_FROM_INT = 4'd9;

	// operand compare flags
	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_t;

	// result status
	typedef struct packed {
		logic ovf;
		logic dz;
	} sts_t;

endpackage

### rtl/core/fpalu_basic.sv
// fpalu_basic: combinational ops (add, sub, min, max, inc, dec,
// to_int, from_int) plus the operand compare. Depends on fpalu_pkg.
module fpalu_basic #(
	parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = fpalu_pkg::WORD_BITS_DEF
) (
	input  logic [fpalu_pkg::FUNC_W-1:0] func,
	input  logic [WORD_BITS-1:0]         op_a,
	input  logic [WORD_BITS-1:0]         op_b,
	output logic [WORD_BITS-1:0]         res,
	output fpalu_pkg::sts_t              sts,
	output fpalu_pkg::cmp_t              cmp
);

	localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] ONE     = {{(WORD_BITS-1){1'b0}}, 1'b1};

	logic [WORD_BITS-1:0] op2, sum, dif, sat_a, mag_a, ti_q, fi_sh, lim;
	logic                 a_neg, op2_neg, sum_ovf, dif_ovf, fi_ovf;

	always_comb begin
		op2     = (func == fpalu_pkg::FN_INC || func == fpalu_pkg::FN_DEC) ? ONE : op_b;
		sum     = op_a + op2;
		dif     = op_a - op2;
		a_neg   = op_a[WORD_BITS-1];
		op2_neg = op2[WORD_BITS-1];
		sum_ovf = (a_neg == op2_neg) && (sum[WORD_BITS-1] != a_neg);
		dif_ovf = (a_neg != op2_neg) && (dif[WORD_BITS-1] != a_neg);
		sat_a   = a_neg ? MIN_NEG : MAX_POS;
		mag_a   = a_neg ? -op_a : op_a;
		ti_q    = mag_a >> FRAC_BITS;
		// MIN_NEG read unsigned is the negative limit magnitude
		lim     = a_neg ? MIN_NEG : MAX_POS;
		fi_ovf  = mag_a > (lim >> FRAC_BITS);
		fi_sh   = mag_a << FRAC_BITS;

		cmp.lt = $signed(op_a) < $signed(op_b);
		cmp.eq = op_a == op_b;
		cmp.gt = $signed(op_a) > $signed(op_b);

		sts.dz = 1'b0;
		case (func)
			fpalu_pkg::FN_ADD, fpalu_pkg::FN_INC: begin
				res     = sum_ovf ? sat_a : sum;
				sts.ovf = sum_ovf;
			end
			fpalu_pkg::FN_SUB, fpalu_pkg::FN_DEC: begin
				res     = dif_ovf ? sat_a : dif;
				sts.ovf = dif_ovf;
			end
			fpalu_pkg::FN_MIN: begin
				res     = cmp.lt ? op_a : op_b;
				sts.ovf = 1'b0;
			end
			fpalu_pkg::FN_MAX: begin
				res     = cmp.gt ? op_a : op_b;
				sts.ovf = 1'b0;
			end
			fpalu_pkg::FN_TO_INT: begin
				res     = a_neg ? -ti_q : ti_q;
				sts.ovf = 1'b0;
			end
			fpalu_pkg::FN_FROM_INT: begin
				res     = fi_ovf ? sat_a : (a_neg ? -fi_sh : fi_sh);
				sts.ovf = fi_ovf;
			end
			default: begin
				// mul and div are filled in downstream; unused codes give zero
				res     = '0;
				sts.ovf = 1'b0;
			end
		endcase
	end

endmodule

### rtl/core/fpalu_mul.sv
// fpalu_mul: three-stage saturating fixed-point multiplier built from four
// half-width partial products. Depends on fpalu_pkg.
module fpalu_mul #(
	parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = fpalu_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic [WORD_BITS-1:0] op_a,
	input  logic [WORD_BITS-1:0] op_b,
	output logic [WORD_BITS-1:0] res,
	output fpalu_pkg::sts_t      sts
);

	localparam int HL = (WORD_BITS + 1) / 2;
	localparam int HH = WORD_BITS - HL;
	localparam int PW = 2 * WORD_BITS;
	localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic [WORD_BITS-1:0] ma, mb;
	logic [2*HL-1:0]      p0_s1;
	logic [HL+HH-1:0]     p1_s1, p2_s1;
	logic [2*HH-1:0]      p3_s1;
	logic                 neg_s1, neg_s2;
	logic [PW-1:0]        prod_s2, sh, lim;
	logic [WORD_BITS-1:0] mag;
	logic                 ovf;
	logic [WORD_BITS-1:0] res_s3;
	logic                 ovf_s3;

	assign ma = op_a[WORD_BITS-1] ? -op_a : op_a;
	assign mb = op_b[WORD_BITS-1] ? -op_b : op_b;

	// stage 1: partial products
	always_ff @(posedge clk) begin
		p0_s1  <= ma[HL-1:0] * mb[HL-1:0];
		p1_s1  <= ma[WORD_BITS-1:HL] * mb[HL-1:0];
		p2_s1  <= ma[HL-1:0] * mb[WORD_BITS-1:HL];
		p3_s1  <= ma[WORD_BITS-1:HL] * mb[WORD_BITS-1:HL];
		neg_s1 <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
	end

	// stage 2: full magnitude product
	always_ff @(posedge clk) begin
		prod_s2 <= (PW'(p3_s1) << (2 * HL)) + (PW'(p1_s1) << HL) + (PW'(p2_s1) << HL)
			+ PW'(p0_s1);
		neg_s2  <= neg_s1;
	end

	// stage 3: drop fraction bits, saturate, apply sign
	always_comb begin
		sh  = prod_s2 >> FRAC_BITS;
		lim = neg_s2 ? PW'(MIN_NEG) : PW'(MAX_POS);
		ovf = sh > lim;
		mag = sh[WORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (ovf) begin
			res_s3 <= neg_s2 ? MIN_NEG : MAX_POS;
		end else begin
			res_s3 <= neg_s2 ? -mag : mag;
		end
		ovf_s3 <= ovf;
	end

	assign res     = res_s3;
	assign sts.ovf = ovf_s3;
	assign sts.dz  = 1'b0;

endmodule

### rtl/core/fpalu_div.sv
// fpalu_div: pipelined restoring divider, one quotient bit per stage, with
// sign handling, saturation and divide-by-zero. Depends on fpalu_pkg.
module fpalu_div #(
	parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = fpalu_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic [WORD_BITS-1:0] op_a,
	input  logic [WORD_BITS-1:0] op_b,
	output logic [WORD_BITS-1:0] res,
	output fpalu_pkg::sts_t      sts
);

	localparam int NB = WORD_BITS + FRAC_BITS;
	localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic [WORD_BITS-1:0] rem_s  [0:NB];
	logic [NB-1:0]        nq_s   [0:NB];
	logic [WORD_BITS-1:0] d_s    [0:NB];
	logic                 neg_s  [0:NB];
	logic                 aneg_s [0:NB];
	logic                 dz_s   [0:NB];

	logic [WORD_BITS-1:0] ma, mb;
	logic [NB-1:0]        q, lim;
	logic                 ovf;
	logic [WORD_BITS-1:0] res_q;
	logic                 ovf_q, dz_q;

	assign ma = op_a[WORD_BITS-1] ? -op_a : op_a;
	assign mb = op_b[WORD_BITS-1] ? -op_b : op_b;

	// prep: numerator is |a| scaled up by the fraction bits
	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		nq_s[0]   <= {ma, {FRAC_BITS{1'b0}}};
		d_s[0]    <= mb;
		neg_s[0]  <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
		aneg_s[0] <= op_a[WORD_BITS-1];
		dz_s[0]   <= op_b == '0;
	end

	// remainder stays below the divisor, so W bits hold it; the trial needs one more
	genvar g;
	generate
		for (g = 0; g < NB; g++) begin : g_iter
			logic [WORD_BITS:0]   trial;
			logic [WORD_BITS-1:0] diff;
			logic                 ge;

			always_comb begin
				trial = {rem_s[g], nq_s[g][NB-1]};
				diff  = trial[WORD_BITS-1:0] - d_s[g];
				ge    = trial >= {1'b0, d_s[g]};
			end

			always_ff @(posedge clk) begin
				rem_s[g+1]  <= ge ? diff : trial[WORD_BITS-1:0];
				nq_s[g+1]   <= {nq_s[g][NB-2:0], ge};
				d_s[g+1]    <= d_s[g];
				neg_s[g+1]  <= neg_s[g];
				aneg_s[g+1] <= aneg_s[g];
				dz_s[g+1]   <= dz_s[g];
			end
		end
	endgenerate

	always_comb begin
		q   = nq_s[NB];
		lim = neg_s[NB] ? {{FRAC_BITS{1'b0}}, MIN_NEG} : {{FRAC_BITS{1'b0}}, MAX_POS};
		ovf = q > lim;
	end

	always_ff @(posedge clk) begin
		if (dz_s[NB]) begin
			res_q <= aneg_s[NB] ? MIN_NEG : MAX_POS;
			ovf_q <= 1'b0;
		end else if (ovf) begin
			res_q <= neg_s[NB] ? MIN_NEG : MAX_POS;
			ovf_q <= 1'b1;
		end else begin
			res_q <= neg_s[NB] ? -q[WORD_BITS-1:0] : q[WORD_BITS-1:0];
			ovf_q <= 1'b0;
		end
		dz_q <= dz_s[NB];
	end

	assign res     = res_q;
	assign sts.ovf = ovf_q;
	assign sts.dz  = dz_q;

endmodule

### rtl/core/fixed_point_q24_8_alu.sv
// fixed_point_q24_8_alu: top level of the pipelined signed Q24.8 ALU.
// Depends on fpalu_pkg, fpalu_basic, fpalu_mul and fpalu_div.
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  -----------------------------------
// command   in         start & !busy             func, operand_a, operand_b
// result    out        done (one-cycle strobe)   result, a_less, a_equal, a_greater,
//                                                overflow, div_by_zero
//
// Cycles: one item accepted every clock; busy never rises. The pipe depth
//   is set by the divider, which resolves one quotient bit of the Q24.8
//   result per stage over WORD_BITS+FRAC_BITS stages; every op rides the
//   same depth so items leave in order.
// Reset: arst_n clears the valid bits only; no payload is reset.
// Stalls: none - the receiver cannot hold results off, so the pipe always moves.
module fixed_point_q24_8_alu #(
	parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = fpalu_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fpalu_pkg::FUNC_W-1:0]  func,
	input  logic signed [WORD_BITS-1:0]   operand_a,
	input  logic signed [WORD_BITS-1:0]   operand_b,
	output logic                          done,
	output logic signed [WORD_BITS-1:0]   result,
	output logic                          a_less,
	output logic                          a_equal,
	output logic                          a_greater,
	output logic                          overflow,
	output logic                          div_by_zero
);

	// latencies counted in registers after the input stage
	localparam int MUL_LAT = 3;
	localparam int DIV_LAT = WORD_BITS + FRAC_BITS + 2;
	// accepting edge to the edge that takes the result
	localparam int OUT_LAT = DIV_LAT + 2;

	localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

	// one slot of the alignment lane
	typedef struct packed {
		logic [fpalu_pkg::FUNC_W-1:0] func;
		logic [WORD_BITS-1:0]         res;
		fpalu_pkg::sts_t              sts;
		fpalu_pkg::cmp_t              cmp;
	} lane_t;

	logic                         accept;
	logic                         vld_s1;
	logic [fpalu_pkg::FUNC_W-1:0] func_s1;
	logic [WORD_BITS-1:0]         a_s1, b_s1;

	logic [WORD_BITS-1:0] bas_res, mul_res, div_res;
	fpalu_pkg::sts_t      bas_sts, mul_sts, div_sts;
	fpalu_pkg::cmp_t      bas_cmp;

	logic  vld_s  [1:DIV_LAT];
	lane_t lane_s [1:DIV_LAT];
	lane_t mul_slot;

	logic                 done_q;
	logic [WORD_BITS-1:0] result_q;
	fpalu_pkg::sts_t      sts_q;
	fpalu_pkg::cmp_t      cmp_q;

	// never stalls: the output side cannot push back
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		a_s1    <= operand_a;
		b_s1    <= operand_b;
	end

	fpalu_basic #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_basic (
		.func(func_s1),
		.op_a(a_s1),
		.op_b(b_s1),
		.res (bas_res),
		.sts (bas_sts),
		.cmp (bas_cmp)
	);

	fpalu_mul #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_mul (
		.clk (clk),
		.op_a(a_s1),
		.op_b(b_s1),
		.res (mul_res),
		.sts (mul_sts)
	);

	fpalu_div #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_div (
		.clk (clk),
		.op_a(a_s1),
		.op_b(b_s1),
		.res (div_res),
		.sts (div_sts)
	);

	// valid bits follow the lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[1] <= vld_s1;
			for (int k = 2; k <= DIV_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// the multiplier's result drops into the lane once it lines up
	always_comb begin
		mul_slot = lane_s[MUL_LAT];
		if (lane_s[MUL_LAT].func == fpalu_pkg::FN_MUL) begin
			mul_slot.res = mul_res;
			mul_slot.sts = mul_sts;
		end
	end

	// lane carries the basic result; the divider's drops in at the output register
	always_ff @(posedge clk) begin
		lane_s[1] <= '{func: func_s1, res: bas_res, sts: bas_sts, cmp: bas_cmp};
		for (int k = 2; k <= DIV_LAT; k++) begin
			lane_s[k] <= (k == MUL_LAT + 1) ? mul_slot : lane_s[k-1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[DIV_LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (lane_s[DIV_LAT].func == fpalu_pkg::FN_DIV) begin
			result_q <= div_res;
			sts_q    <= div_sts;
		end else begin
			result_q <= lane_s[DIV_LAT].res;
			sts_q    <= lane_s[DIV_LAT].sts;
		end
		cmp_q <= lane_s[DIV_LAT].cmp;
	end

	assign done        = done_q;
	assign result      = result_q;
	assign a_less      = cmp_q.lt;
	assign a_equal     = cmp_q.eq;
	assign a_greater   = cmp_q.gt;
	assign overflow    = sts_q.ovf;
	assign div_by_zero = sts_q.dz;

	// every accepted item comes out after the fixed pipe depth
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##OUT_LAT done)
		else $error("accepted item did not emerge on time");

	// exactly one compare flag on every result
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({a_less, a_equal, a_greater}))
		else $error("compare flags not one-hot");

	// divide by zero saturates without raising overflow
	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_by_zero) |-> !overflow)
		else $error("overflow raised with divide by zero");

	// an overflow always leaves a saturated value
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> ($unsigned(result) == MAX_POS || $unsigned(result) == MIN_NEG))
		else $error("overflow without saturated result");

endmodule

### tb/sv/tb.sv
// tb: self-checking bench for the Q24.8 fixed-point ALU, with its own exact-arithmetic predictor.
// Depends on fpalu_pkg and fixed_point_q24_8_alu.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpalu_pkg::*;

	localparam int W        = WORD_BITS_DEF;
	localparam int F        = FRAC_BITS_DEF;
	localparam int FUNC_TOP = (1 << FUNC_W) - 1;   // highest code the port can carry
	localparam int LATENCY  = W + F + 3;           // accepting edge to done
	localparam int TAIL     = LATENCY + 20;        // quiet time after the last result
	localparam int IDLE_PCT = 19;
	localparam int N_RANDOM = 1200;
	localparam int LIMIT    = 200000;              // cycles before the run is abandoned

	typedef logic signed [W-1:0] word_t;

	localparam longint WMAX  = (longint'(1) <<< (W - 1)) - 1;
	localparam longint WMIN  = -(longint'(1) <<< (W - 1));
	localparam longint SCALE = longint'(1) <<< F;

	// one command item, plus the sender's pacing for it
	typedef struct {
		logic [FUNC_W-1:0] op;
		word_t             a;
		word_t             b;
		bit                no_gap;       // sender does not idle at random in front of it
		bit                drain_first;  // held back until every result is in
	} cmd_t;

	// one result item as the block should give it
	typedef struct {
		word_t value;
		logic  lt;
		logic  eq;
		logic  gt;
		logic  ovf;
		logic  dz;
	} alu_out_t;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic [FUNC_W-1:0] func      = '0;
	word_t             operand_a = '0;
	word_t             operand_b = '0;
	logic              busy;
	logic              done;
	word_t             result;
	logic              a_less;
	logic              a_equal;
	logic              a_greater;
	logic              overflow;
	logic              div_by_zero;

	cmd_t     pending_q[$];   // items still to be offered
	alu_out_t expected_q[$];  // predicted results, oldest first
	int       errors = 0;
	int       cycles = 0;

	fixed_point_q24_8_alu i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.done        (done),
		.result      (result),
		.a_less      (a_less),
		.a_equal     (a_equal),
		.a_greater   (a_greater),
		.overflow    (overflow),
		.div_by_zero (div_by_zero)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Clamp an exact value into the word, noting whether it had to be clamped.
	function automatic word_t clamp(input longint v, output logic sat);
		sat = (v > WMAX) || (v < WMIN);
		if (v > WMAX)
			return word_t'(WMAX);
		if (v < WMIN)
			return word_t'(WMIN);
		return word_t'(v);
	endfunction

	// Expected result of one item. Operands are at most 32 bits wide, so every
	// intermediate (product, scaled dividend) fits a 64-bit signed value, and
	// SV signed division already truncates toward zero.
	function automatic alu_out_t alu_predict(input cmd_t c);
		alu_out_t r;
		longint   sa;
		longint   sb;
		sa    = c.a;
		sb    = c.b;
		r.ovf = 1'b0;
		r.dz  = 1'b0;
		r.lt  = sa < sb;
		r.eq  = sa == sb;
		r.gt  = sa > sb;
		case (c.op)
			FN_ADD:      r.value = clamp(sa + sb, r.ovf);
			FN_SUB:      r.value = clamp(sa - sb, r.ovf);
			FN_MUL:      r.value = clamp((sa * sb) / SCALE, r.ovf);
			FN_DIV: begin
				if (sb == 0) begin
					// zero divisor: saturate by the sign of the dividend, no overflow
					r.dz    = 1'b1;
					r.value = (sa < 0) ? word_t'(WMIN) : word_t'(WMAX);
				end else begin
					r.value = clamp((sa * SCALE) / sb, r.ovf);
				end
			end
			FN_MIN:      r.value = (sa < sb) ? c.a : c.b;
			FN_MAX:      r.value = (sb < sa) ? c.a : c.b;
			FN_INC:      r.value = clamp(sa + 1, r.ovf);
			FN_DEC:      r.value = clamp(sa - 1, r.ovf);
			FN_TO_INT:   r.value = word_t'(sa / SCALE);
			FN_FROM_INT: r.value = clamp(sa * SCALE, r.ovf);
			default:     r.value = '0;   // unused codes give zero, flags still valid
		endcase
		return r;
	endfunction

	// Operand with a bias toward the edges that matter: the word extremes,
	// small values, the from_int limit and magnitudes where products just overflow.
	function automatic word_t pick_operand();
		word_t v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0:       v = word_t'(WMAX);
					1:       v = word_t'(WMIN);
					2:       v = '0;
					3:       v = 1;
					default: v = -1;
				endcase
			end
			1: v = word_t'(int'($urandom_range(0, 1023)) - 512);
			2: v = word_t'((longint'(1) <<< (W - 1 - F)) + $urandom_range(0, 4) - 2);
			3: v = word_t'($urandom_range(0, 1 << 20));
			default: v = word_t'($urandom);
		endcase
		if ($urandom_range(0, 1) && v != word_t'(WMIN))
			v = -v;
		return v;
	endfunction

	task automatic queue_cmd(input logic [FUNC_W-1:0] op, input word_t a, input word_t b,
			input bit no_gap, input bit drain_first);
		cmd_t c;
		c.op          = op;
		c.a           = a;
		c.b           = b;
		c.no_gap      = no_gap;
		c.drain_first = drain_first;
		pending_q.push_back(c);
	endtask

	task automatic check_field(input string name, input word_t want, input word_t got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	// Sender: offers the item at the head of the queue, records its prediction
	// once it is taken, and idles at random except in the gap-free stretch.
	always @(posedge clk) begin : sender
		cmd_t nxt;
		logic go;
		if (arst_n) begin
			if (start && !busy) begin
				expected_q.push_back(alu_predict(pending_q[0]));
				void'(pending_q.pop_front());
			end
			if (start && busy) begin
				// item still waiting for the block: hold it as it is
			end else begin
				go = 1'b0;
				if (pending_q.size() > 0) begin
					nxt = pending_q[0];
					go  = (nxt.no_gap || $urandom_range(0, 99) >= IDLE_PCT) &&
						(!nxt.drain_first || expected_q.size() == 0);
				end
				start <= go;
				if (go) begin
					func      <= nxt.op;
					operand_a <= nxt.a;
					operand_b <= nxt.b;
				end
			end
		end
	end

	// Receiver: every done strobe must match the oldest prediction.
	always @(posedge clk) begin : receiver
		alu_out_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result expected none got %0d", $time, result);
			end else begin
				want = expected_q.pop_front();
				check_field("result", want.value, result);
				check_field("a_less", word_t'(want.lt), word_t'(a_less));
				check_field("a_equal", word_t'(want.eq), word_t'(a_equal));
				check_field("a_greater", word_t'(want.gt), word_t'(a_greater));
				check_field("overflow", word_t'(want.ovf), word_t'(overflow));
				check_field("div_by_zero", word_t'(want.dz), word_t'(div_by_zero));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin : run
		cmd_t c;
		int   n;
		word_t wmax;
		word_t wmin;
		word_t lim;
		wmax = word_t'(WMAX);
		wmin = word_t'(WMIN);
		lim  = word_t'(longint'(1) <<< (W - 1 - F));   // first integer from_int cannot hold

		// directed: saturation both ways, truncation toward zero, zero divisor
		queue_cmd(FN_ADD, wmax, 1, 1, 0);
		queue_cmd(FN_ADD, wmin, wmin, 0, 0);
		queue_cmd(FN_SUB, wmin, 1, 0, 0);
		queue_cmd(FN_SUB, wmax, -1, 0, 0);
		queue_cmd(FN_MUL, wmax, wmax, 0, 0);
		queue_cmd(FN_MUL, wmin, wmin, 0, 0);
		queue_cmd(FN_MUL, -1, 1, 0, 0);          // product below one LSB, rounds to zero
		queue_cmd(FN_DIV, 256, 0, 0, 0);
		queue_cmd(FN_DIV, -5, 0, 0, 0);
		queue_cmd(FN_DIV, 0, 0, 0, 0);           // zero over zero counts as non-negative
		queue_cmd(FN_DIV, -256, 768, 0, 0);      // negative quotient truncated toward zero
		queue_cmd(FN_MIN, wmin, wmin, 0, 0);
		queue_cmd(FN_MAX, wmax, wmin, 0, 0);
		queue_cmd(FN_INC, wmax, 0, 0, 0);
		queue_cmd(FN_DEC, wmin, 0, 0, 0);
		queue_cmd(FN_TO_INT, -1, 0, 0, 0);
		queue_cmd(FN_TO_INT, wmin, wmax, 0, 0);
		queue_cmd(FN_FROM_INT, lim, 0, 0, 0);
		queue_cmd(FN_FROM_INT, -lim, 0, 0, 0);
		queue_cmd(FN_FROM_INT, -lim - 1, 0, 0, 0);
		queue_cmd(FUNC_W'(FN_FROM_INT + 1), 7, 7, 0, 0);
		queue_cmd(FUNC_W'(FUNC_TOP), wmin, wmax, 0, 0);

		// random: mostly real op codes, some unused ones; equal operands and
		// zero divisors forced now and then; one gap-free stretch in the middle
		for (n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 9) == 0)
				c.op = FUNC_W'($urandom_range(0, FUNC_TOP));
			else
				c.op = FUNC_W'($urandom_range(0, FN_FROM_INT));
			c.a = pick_operand();
			c.b = pick_operand();
			if ($urandom_range(0, 7) == 0)
				c.b = c.a;
			if (c.op == FN_DIV && $urandom_range(0, 7) == 0)
				c.b = '0;
			c.no_gap      = (n >= 400 && n < 700);
			c.drain_first = (n % 300 == 0) || (n == 853);
			pending_q.push_back(c);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
